// File: sv/bounded_span_stack_merge_macros.svh
// Assertion macros used by the checker file.
`ifndef BOUNDED_SPAN_STACK_MERGE_MACROS_SVH
`define BOUNDED_SPAN_STACK_MERGE_MACROS_SVH
// Whenever the condition holds, the consequence holds at the same edge.
`define BSSM_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Whenever the condition holds, the consequence holds at the next edge.
`define BSSM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

// File: sv/bssm_pkg.sv
package bssm_pkg;

  localparam int MaxSpans   = 8;
  localparam int HeightBits = 24;
  localparam int FieldBits  = 24;
  localparam int CountBits  = 4;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_SIMPLIFY = 2'd1,
    OP_READ     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  localparam logic CFG_MERGE_GAP = 1'b0;
  localparam logic CFG_THICKNESS = 1'b1;

  typedef struct packed {
    logic [1:0]                  op;
    logic signed [FieldBits-1:0] span_top;
    logic signed [FieldBits-1:0] span_bottom;
    logic [15:0]                 span_normal;
    logic [7:0]                  span_shade;
    logic [15:0]                 span_material;
    logic [7:0]                  span_marks;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] res_top;
    logic signed [FieldBits-1:0] res_bottom;
    logic [15:0]                 res_normal;
    logic [7:0]                  res_shade;
    logic [15:0]                 res_material;
    logic [7:0]                  res_marks;
    logic [CountBits-1:0]        res_count;
    logic                        res_valid;
    logic                        res_last;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_GAP,
    ST_DECIDE,
    ST_SHIFT,
    ST_SIMP_MERGE,
    ST_SIMP_THIN,
    ST_READ,
    ST_DONE
  } state_t;

  // Where the sort goes when it finishes.
  typedef enum logic [1:0] {
    AFT_GAP,
    AFT_DONE,
    AFT_SIMP
  } after_t;

endpackage

// File: sv/bssm_cmp.sv
// Shared arithmetic unit: one exact signed subtract and its compares.
module bssm_cmp #(
  parameter int HEIGHT_BITS = bssm_pkg::HeightBits
) (
  input  logic signed [HEIGHT_BITS-1:0] a,
  input  logic signed [HEIGHT_BITS-1:0] b,
  input  logic signed [HEIGHT_BITS:0]   lim,
  output logic signed [HEIGHT_BITS:0]   diff,
  output logic                          a_lt_b,
  output logic                          le_lim,
  output logic                          ge_lim
);
  // The difference is one bit wider so it never wraps.
  assign diff   = {a[HEIGHT_BITS-1], a} - {b[HEIGHT_BITS-1], b};
  assign a_lt_b = diff[HEIGHT_BITS];
  assign le_lim = diff <= lim;
  assign ge_lim = diff >= lim;
endmodule

// File: sv/bounded_span_stack_merge.sv
// Bounded span stack with merging. Up to MAX_SPANS spans (signed Q16.8 top and bottom plus
// top-surface attributes) sit in a small register store. One item is taken at a time, and the
// input stalls until the last result of that item has been accepted. A push with room and a
// clear go to the done state and then present their one status result from the output
// register. A read out gives one result per stored span, one per cycle while the output is
// not stalled, or one status result when the store is empty. A push into a full store and a
// simplify run a sequencer around one shared subtract/compare unit. The sort is an insertion
// sort with one compare per cycle. A full push then scans the MAX_SPANS-1 gaps and decides.
// It either merges the new span into the lowest one, or merges the closest pair, closes the
// hole and sorts again, where only the new span moves. A simplify runs a sort, one merge pass
// and one thin-span pass.
module bounded_span_stack_merge #(
  parameter int MAX_SPANS   = bssm_pkg::MaxSpans,
  parameter int HEIGHT_BITS = bssm_pkg::HeightBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bssm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bssm_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [23:0]          cfg_data
);
  localparam int IW = $clog2(MAX_SPANS);
  localparam int CW = $clog2(MAX_SPANS + 1);
  localparam int FB = bssm_pkg::FieldBits;
  localparam int HW = HEIGHT_BITS;
  localparam logic [CW-1:0] FULL = CW'(MAX_SPANS);

  typedef struct packed {
    logic signed [HW-1:0] top;
    logic signed [HW-1:0] bottom;
    logic [39:0]          attr;
    logic [7:0]           flags;
  } span_t;

  // Span store: fixed registers, no reset.
  span_t store_r [MAX_SPANS];
  logic [CW-1:0] count_r;
  logic signed [HW:0] gap_lim_r, thk_lim_r;

  bssm_pkg::state_t state_r, state_nxt;
  bssm_pkg::after_t after_r;
  logic [CW-1:0] i_r, j_r, w_r, best_r;
  logic signed [HW:0] min_gap_r;
  span_t key_r, in_span_r;
  span_t in_span;
  bssm_pkg::out_item_t out_data_nxt;
  logic emit_now;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != bssm_pkg::ST_IDLE) || out_valid;

  // Incoming item as a span.
  always_comb begin
    in_span.top    = HW'(in_data.span_top);
    in_span.bottom = HW'(in_data.span_bottom);
    in_span.attr   = {in_data.span_material, in_data.span_shade, in_data.span_normal};
    in_span.flags  = in_data.span_marks;
  end

  // Combine src into dst.
  function automatic span_t combine(span_t d, span_t s);
    span_t r;
    r = d;
    if (s.top > d.top) begin
      r.top = s.top;
      r.attr = s.attr;
      r.flags[0] = s.flags[0];
    end
    if (s.bottom < d.bottom) begin
      r.bottom = s.bottom;
      r.flags[1] = s.flags[1];
    end
    r.flags[2] = 1'b1;
    return r;
  endfunction

  // Operand selection for the shared unit.
  logic signed [HW-1:0] cmp_a, cmp_b;
  logic signed [HW:0]   cmp_lim, cmp_diff;
  logic                 cmp_lt, cmp_le, cmp_ge;
  span_t jm1, rd_span, wm1;
  assign jm1 = store_r[IW'(j_r - CW'(1))];
  assign rd_span = store_r[IW'(i_r)];
  assign wm1 = store_r[IW'(w_r - CW'(1))];

  always_comb begin
    cmp_a = jm1.top;
    cmp_b = key_r.top;
    cmp_lim = gap_lim_r;
    unique case (state_r)
      bssm_pkg::ST_GAP: begin
        cmp_a = store_r[IW'(i_r)].bottom;
        cmp_b = store_r[IW'(i_r + CW'(1))].top;
      end
      bssm_pkg::ST_DECIDE: begin
        cmp_a = store_r[IW'(count_r - CW'(1))].bottom;
        cmp_b = in_span_r.top;
      end
      bssm_pkg::ST_SIMP_MERGE: begin
        cmp_a = wm1.bottom;
        cmp_b = rd_span.top;
      end
      bssm_pkg::ST_SIMP_THIN: begin
        cmp_a = rd_span.top;
        cmp_b = rd_span.bottom;
        cmp_lim = thk_lim_r;
      end
      default: begin
        cmp_a = jm1.top;
        cmp_b = key_r.top;
      end
    endcase
  end

  bssm_cmp #(.HEIGHT_BITS(HW)) u_cmp (
    .a(cmp_a), .b(cmp_b), .lim(cmp_lim), .diff(cmp_diff),
    .a_lt_b(cmp_lt), .le_lim(cmp_le), .ge_lim(cmp_ge)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bssm_pkg::ST_IDLE:
        if (in_valid && !in_stall) begin
          unique case (bssm_pkg::op_t'(in_data.op))
            bssm_pkg::OP_PUSH:
              state_nxt = (count_r < FULL) ? bssm_pkg::ST_DONE : bssm_pkg::ST_SORT;
            bssm_pkg::OP_SIMPLIFY:
              state_nxt = (count_r == '0) ? bssm_pkg::ST_DONE : bssm_pkg::ST_SORT;
            bssm_pkg::OP_READ:
              state_nxt = (count_r == '0) ? bssm_pkg::ST_DONE : bssm_pkg::ST_READ;
            default: state_nxt = bssm_pkg::ST_DONE;
          endcase
        end
      bssm_pkg::ST_SORT:
        if (i_r >= count_r) begin
          unique case (after_r)
            bssm_pkg::AFT_GAP:  state_nxt = bssm_pkg::ST_GAP;
            bssm_pkg::AFT_SIMP: state_nxt = bssm_pkg::ST_SIMP_MERGE;
            default:            state_nxt = bssm_pkg::ST_DONE;
          endcase
        end
      bssm_pkg::ST_GAP:
        if (i_r + CW'(2) >= count_r) state_nxt = bssm_pkg::ST_DECIDE;
      bssm_pkg::ST_DECIDE:
        state_nxt = (!cmp_diff[HW] && cmp_diff < min_gap_r) ? bssm_pkg::ST_DONE
                                                            : bssm_pkg::ST_SHIFT;
      bssm_pkg::ST_SHIFT:
        if (i_r + CW'(1) >= count_r) state_nxt = bssm_pkg::ST_SORT;
      bssm_pkg::ST_SIMP_MERGE:
        if (i_r + CW'(1) >= count_r) state_nxt = bssm_pkg::ST_SIMP_THIN;
      bssm_pkg::ST_SIMP_THIN:
        if (i_r + CW'(1) >= count_r) state_nxt = bssm_pkg::ST_DONE;
      bssm_pkg::ST_READ:
        if (!out_valid || !out_stall)
          if (i_r + CW'(1) >= count_r) state_nxt = bssm_pkg::ST_IDLE;
      bssm_pkg::ST_DONE:
        if (!out_valid || !out_stall) state_nxt = bssm_pkg::ST_IDLE;
      default: state_nxt = bssm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bssm_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Result contents: a stored span while reading out, a status result otherwise.
  assign emit_now = (state_r == bssm_pkg::ST_READ) || (state_r == bssm_pkg::ST_DONE);

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt.res_count = bssm_pkg::CountBits'(count_r);
    if (state_r == bssm_pkg::ST_READ) begin
      out_data_nxt.res_top      = FB'(rd_span.top);
      out_data_nxt.res_bottom   = FB'(rd_span.bottom);
      out_data_nxt.res_normal   = rd_span.attr[15:0];
      out_data_nxt.res_shade    = rd_span.attr[23:16];
      out_data_nxt.res_material = rd_span.attr[39:24];
      out_data_nxt.res_marks    = rd_span.flags;
      out_data_nxt.res_valid    = 1'b1;
      out_data_nxt.res_last     = (i_r + CW'(1) >= count_r);
    end else begin
      out_data_nxt.res_last = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= emit_now;
      if (emit_now) out_data <= out_data_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_lim_r <= '0;
      thk_lim_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bssm_pkg::CFG_MERGE_GAP)
        gap_lim_r <= (HW+1)'($signed(cfg_data));
      else
        thk_lim_r <= (HW+1)'($signed(cfg_data));
    end
  end

  // Datapath and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      i_r <= '0;
      j_r <= '0;
      w_r <= '0;
      best_r <= '0;
      after_r <= bssm_pkg::AFT_DONE;
    end else begin
      unique case (state_r)
        bssm_pkg::ST_IDLE:
          if (in_valid && !in_stall) begin
            in_span_r <= in_span;
            j_r <= CW'(1);
            key_r <= store_r[IW'(CW'(1))];
            after_r <= (in_data.op == bssm_pkg::OP_PUSH) ? bssm_pkg::AFT_GAP
                                                         : bssm_pkg::AFT_SIMP;
            unique case (bssm_pkg::op_t'(in_data.op))
              bssm_pkg::OP_PUSH:
                if (count_r < FULL) begin
                  store_r[IW'(count_r)] <= in_span;
                  count_r <= count_r + CW'(1);
                  i_r <= '0;
                end else begin
                  i_r <= CW'(1);
                end
              bssm_pkg::OP_SIMPLIFY: i_r <= CW'(1);
              bssm_pkg::OP_CLEAR: begin
                count_r <= '0;
                i_r <= '0;
              end
              default: i_r <= '0;
            endcase
          end
        // Insertion sort, one compare per cycle; i is the key index.
        bssm_pkg::ST_SORT:
          if (i_r < count_r) begin
            if (j_r != '0 && cmp_lt) begin
              store_r[IW'(j_r)] <= jm1;
              j_r <= j_r - CW'(1);
            end else begin
              store_r[IW'(j_r)] <= key_r;
              i_r <= i_r + CW'(1);
              j_r <= i_r + CW'(1);
              key_r <= store_r[IW'(i_r + CW'(1))];
            end
          end else begin
            i_r <= (after_r == bssm_pkg::AFT_SIMP) ? CW'(1) : '0;
            w_r <= CW'(1);
            best_r <= '0;
          end
        // Gap scan for the closest adjacent pair.
        bssm_pkg::ST_GAP: begin
          if (i_r == '0 || cmp_diff < min_gap_r) begin
            min_gap_r <= cmp_diff;
            best_r <= i_r;
          end
          i_r <= i_r + CW'(1);
        end
        bssm_pkg::ST_DECIDE:
          if (!cmp_diff[HW] && cmp_diff < min_gap_r) begin
            store_r[IW'(count_r - CW'(1))] <=
              combine(store_r[IW'(count_r - CW'(1))], in_span_r);
          end else begin
            store_r[IW'(best_r)] <=
              combine(store_r[IW'(best_r)], store_r[IW'(best_r + CW'(1))]);
            i_r <= best_r + CW'(1);
          end
        // Close the hole and put the new span last.
        bssm_pkg::ST_SHIFT: begin
          if (i_r + CW'(1) < count_r) begin
            store_r[IW'(i_r)] <= store_r[IW'(i_r + CW'(1))];
            i_r <= i_r + CW'(1);
          end else begin
            store_r[IW'(count_r - CW'(1))] <= in_span_r;
            i_r <= CW'(1);
            j_r <= CW'(1);
            // With two slots the new span itself is the first key.
            key_r <= (count_r == CW'(2)) ? in_span_r : store_r[IW'(CW'(1))];
            after_r <= bssm_pkg::AFT_DONE;
          end
        end
        // Merge pass: i reads, w writes.
        bssm_pkg::ST_SIMP_MERGE: begin
          if (i_r < count_r) begin
            if (cmp_le) store_r[IW'(w_r - CW'(1))] <= combine(wm1, rd_span);
            else        store_r[IW'(w_r)] <= rd_span;
          end
          if (i_r + CW'(1) >= count_r) begin
            count_r <= (i_r < count_r && !cmp_le) ? w_r + CW'(1) : w_r;
            i_r <= CW'(1);
            w_r <= CW'(1);
          end else begin
            i_r <= i_r + CW'(1);
            if (!cmp_le) w_r <= w_r + CW'(1);
          end
        end
        // Thin span removal, the first span always stays.
        bssm_pkg::ST_SIMP_THIN: begin
          if (i_r < count_r) begin
            if (cmp_ge) begin
              store_r[IW'(w_r)] <= rd_span;
              w_r <= w_r + CW'(1);
            end
          end
          if (i_r + CW'(1) >= count_r) begin
            if (i_r < count_r) count_r <= cmp_ge ? w_r + CW'(1) : w_r;
            else count_r <= w_r;
          end
          i_r <= i_r + CW'(1);
        end
        bssm_pkg::ST_READ:
          if (!out_valid || !out_stall) i_r <= i_r + CW'(1);
        default: ;
      endcase
    end
  end

endmodule

// File: sv/bssm_checker.sv
`include "bounded_span_stack_merge_macros.svh"
// Port-level checks on the span stack.
module bssm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bssm_pkg::out_item_t out_data
);
  // An accepted item blocks the input on the next cycle.
  `BSSM_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input not held off")
  // A result that is not a span is always the final one.
  `BSSM_ASSERT_IMPL(a_lastv, clk, rst_n, out_valid && !out_data.res_valid, out_data.res_last, "bad last")
  // The count never exceeds the store depth.
  `BSSM_ASSERT_IMPL(a_cnt, clk, rst_n, out_valid, out_data.res_count <= 4'(bssm_pkg::MaxSpans), "count")
  // A stalled result holds.
  `BSSM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "hold")
endmodule

bind bounded_span_stack_merge bssm_checker u_bssm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: verif/tb_top.sv
module tb_top;

  localparam int SpanSlots = bssm_pkg::MaxSpans;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;

  // One stored span inside the span store mirror.
  typedef struct {
    longint      top;
    longint      bottom;
    logic [15:0] normal;
    logic [7:0]  shade;
    logic [15:0] material;
    logic [7:0]  marks;
  } span_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bssm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bssm_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = bssm_pkg::CFG_MERGE_GAP;
  logic [23:0] cfg_data = '0;

  bounded_span_stack_merge dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the span store and the two limits.
  span_rec_t stack_mem[SpanSlots];
  int        stack_depth = 0;
  longint    gap_limit = 0;
  longint    thin_limit = 0;

  bssm_pkg::in_item_t  pending_items[$];
  bssm_pkg::out_item_t expected_spans[$];
  int        errors = 0;
  int        cycles = 0;
  bit        hold_long = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        hold_count = 0;

  function automatic void queue_item(bssm_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void expect_result(bssm_pkg::out_item_t r);
    expected_spans.insert(expected_spans.size(), r);
  endfunction

  // Stable insertion sort, higher top first.
  function automatic void sort_down();
    span_rec_t key;
    int j;
    for (int i = 1; i < stack_depth; i++) begin
      key = stack_mem[i];
      j = i;
      while (j > 0 && stack_mem[j-1].top < key.top) begin
        stack_mem[j] = stack_mem[j-1];
        j--;
      end
      stack_mem[j] = key;
    end
  endfunction

  // Fold src into slot d: higher top and lower bottom win.
  function automatic void fold_into(int d, span_rec_t src);
    span_rec_t dst;
    dst = stack_mem[d];
    if (src.top > dst.top) begin
      dst.top = src.top;
      dst.normal = src.normal;
      dst.shade = src.shade;
      dst.material = src.material;
      dst.marks[0] = src.marks[0];
    end
    if (src.bottom < dst.bottom) begin
      dst.bottom = src.bottom;
      dst.marks[1] = src.marks[1];
    end
    dst.marks[2] = 1'b1;
    stack_mem[d] = dst;
  endfunction

  function automatic bssm_pkg::out_item_t status_result();
    bssm_pkg::out_item_t r;
    r = '0;
    r.res_count = stack_depth[3:0];
    r.res_last = 1'b1;
    return r;
  endfunction

  // Works out the results of one accepted item and updates the mirror.
  function automatic void predict_spans(bssm_pkg::in_item_t it);
    span_rec_t s;
    bssm_pkg::out_item_t r;
    longint min_gap, g, inc_gap;
    int best, w;
    case (bssm_pkg::op_t'(it.op))
      bssm_pkg::OP_PUSH: begin
        s.top = longint'(it.span_top);
        s.bottom = longint'(it.span_bottom);
        s.normal = it.span_normal;
        s.shade = it.span_shade;
        s.material = it.span_material;
        s.marks = it.span_marks;
        if (stack_depth < SpanSlots) begin
          stack_mem[stack_depth] = s;
          stack_depth++;
        end else begin
          sort_down();
          best = 0;
          min_gap = stack_mem[0].bottom - stack_mem[1].top;
          for (int i = 1; i + 1 < stack_depth; i++) begin
            g = stack_mem[i].bottom - stack_mem[i+1].top;
            if (g < min_gap) begin
              min_gap = g;
              best = i;
            end
          end
          inc_gap = stack_mem[stack_depth-1].bottom - s.top;
          if (inc_gap >= 0 && inc_gap < min_gap) begin
            fold_into(stack_depth - 1, s);
          end else begin
            fold_into(best, stack_mem[best+1]);
            for (int i = best + 1; i + 1 < stack_depth; i++) stack_mem[i] = stack_mem[i+1];
            stack_mem[stack_depth-1] = s;
            sort_down();
          end
        end
        expect_result(status_result());
      end
      bssm_pkg::OP_SIMPLIFY: begin
        if (stack_depth > 0) begin
          sort_down();
          w = 0;
          for (int i = 0; i < stack_depth; i++) begin
            if (w > 0 && (stack_mem[w-1].bottom - stack_mem[i].top) <= gap_limit)
              fold_into(w - 1, stack_mem[i]);
            else begin
              stack_mem[w] = stack_mem[i];
              w++;
            end
          end
          stack_depth = w;
          w = 0;
          for (int i = 0; i < stack_depth; i++) begin
            if (i == 0 || (stack_mem[i].top - stack_mem[i].bottom) >= thin_limit) begin
              stack_mem[w] = stack_mem[i];
              w++;
            end
          end
          stack_depth = w;
        end
        expect_result(status_result());
      end
      bssm_pkg::OP_CLEAR: begin
        stack_depth = 0;
        expect_result(status_result());
      end
      default: begin
        if (stack_depth == 0) expect_result(status_result());
        for (int i = 0; i < stack_depth; i++) begin
          r = '0;
          r.res_top = stack_mem[i].top[23:0];
          r.res_bottom = stack_mem[i].bottom[23:0];
          r.res_normal = stack_mem[i].normal;
          r.res_shade = stack_mem[i].shade;
          r.res_material = stack_mem[i].material;
          r.res_marks = stack_mem[i].marks;
          r.res_count = stack_depth[3:0];
          r.res_valid = 1'b1;
          r.res_last = (i + 1 == stack_depth);
          expect_result(r);
        end
      end
    endcase
  endfunction

  function automatic bssm_pkg::in_item_t make_span(int top, int bottom);
    bssm_pkg::in_item_t it;
    it.op = bssm_pkg::OP_PUSH;
    it.span_top = top[23:0];
    it.span_bottom = bottom[23:0];
    it.span_normal = $urandom();
    it.span_shade = $urandom();
    it.span_material = $urandom();
    it.span_marks = $urandom();
    return it;
  endfunction

  function automatic bssm_pkg::in_item_t make_cmd(bssm_pkg::op_t op);
    bssm_pkg::in_item_t it;
    it = make_span($urandom(), $urandom());
    it.op = op;
    return it;
  endfunction

  // Random span: mostly clustered small heights, sometimes full range.
  function automatic bssm_pkg::in_item_t random_span();
    int t, h;
    if ($urandom_range(0, 9) == 0) return make_span($urandom(), $urandom());
    t = $urandom_range(0, 8000) - 4000;
    h = $urandom_range(0, 600) - 50;
    return make_span(t, t - h);
  endfunction

  // Driver: offers queued items with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_spans(in_data);
        void'(pending_items.pop_front());
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (!in_valid && in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (!in_valid && pending_items.size() > 0) begin
        in_data <= pending_items[0];
        in_valid <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  always @(posedge clk) begin
    if (rst_n && hold_long && hold_count < HoldCycles) hold_count <= hold_count + 1;
  end

  // Monitor: checks results and draws stalls.
  always @(posedge clk) begin
    bssm_pkg::out_item_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_r = expected_spans.pop_front();
          if (out_data !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, out_data);
          end
        end
        out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
      if (hold_long && hold_count < HoldCycles) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0 && !(out_valid && !out_stall)) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (out_valid && !out_stall && $urandom_range(0, 1) == 1);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_spans.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_index <= idx;
    cfg_data <= value[23:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == bssm_pkg::CFG_MERGE_GAP) gap_limit = value;
    else thin_limit = value;
  endtask

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 13) queue_item(random_span());
      else if (k < 15) queue_item(make_cmd(bssm_pkg::OP_SIMPLIFY));
      else if (k < 19) queue_item(make_cmd(bssm_pkg::OP_READ));
      else queue_item(make_cmd(bssm_pkg::OP_CLEAR));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, extremes, full-store merges, simplify, clear.
    queue_item(make_cmd(bssm_pkg::OP_READ));
    queue_item(make_cmd(bssm_pkg::OP_SIMPLIFY));
    queue_item(make_span(8388607, -8388608));
    queue_item(make_span(-8388608, 8388607));
    for (int i = 0; i < 6; i++) queue_item(make_span(1000 - i * 100, 950 - i * 100));
    queue_item(make_span(2000, 1500));
    queue_item(make_span(-5000, -5100));
    queue_item(make_span(-8388608, -8388608));
    queue_item(make_cmd(bssm_pkg::OP_READ));
    queue_item(make_cmd(bssm_pkg::OP_SIMPLIFY));
    queue_item(make_cmd(bssm_pkg::OP_READ));
    queue_item(make_cmd(bssm_pkg::OP_CLEAR));
    queue_item(make_cmd(bssm_pkg::OP_READ));
    wait_idle();

    write_reg(bssm_pkg::CFG_MERGE_GAP, 8388607);
    write_reg(bssm_pkg::CFG_THICKNESS, -8388608);
    for (int i = 0; i < 5; i++) queue_item(random_span());
    queue_item(make_cmd(bssm_pkg::OP_SIMPLIFY));
    queue_item(make_cmd(bssm_pkg::OP_READ));
    wait_idle();

    // Long receiver hold-off so the block backs up.
    hold_long = 1'b1;
    random_phase(20);
    wait_idle();
    hold_long = 1'b0;

    write_reg(bssm_pkg::CFG_MERGE_GAP, -8388608);
    write_reg(bssm_pkg::CFG_THICKNESS, 8388607);
    random_phase(60);
    wait_idle();

    write_reg(bssm_pkg::CFG_MERGE_GAP, 64);
    write_reg(bssm_pkg::CFG_THICKNESS, 100);
    random_phase(110);
    wait_idle();

    write_reg(bssm_pkg::CFG_MERGE_GAP, $urandom_range(0, 2000) - 1000);
    write_reg(bssm_pkg::CFG_THICKNESS, $urandom_range(0, 400) - 100);
    random_phase(100);
    wait_idle();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
